/* design/tgad_pkg.sv */
// Package for the TGA stream decoder: phase, result kind and error codes, header constants.
`timescale 1ns / 1ps

package tgad_pkg;

  localparam int unsigned SigLen      = 12;
  localparam int unsigned InfoLen     = 6;
  localparam int unsigned IdxW        = 5;
  localparam logic [IdxW-1:0] TypeIdx = 5'd2;
  localparam logic [IdxW-1:0] InfoEnd = 5'(SigLen + InfoLen - 1);
  localparam logic [7:0] TypeRaw      = 8'd2;
  localparam logic [7:0] TypeRle      = 8'd10;
  localparam logic [7:0] Depth24      = 8'd24;
  localparam logic [7:0] Depth32      = 8'd32;

  localparam int unsigned TdataOutW   = 80;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SIG  = 3'd1,
    PH_INFO = 3'd2,
    PH_PKT  = 3'd3,
    PH_PIX  = 3'd4,
    PH_DONE = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_INFO  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_SIGNATURE = 2'd0,
    ERR_INFO      = 2'd1,
    ERR_OVERRUN   = 2'd2
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    err_e        error_code;
    logic        last;
  } result_t;

endpackage

/* design/tga_image_stream_decoder.sv */
// TGA image stream decoder: byte-wide file parser producing info, pixel and error records.
`timescale 1ns / 1ps

// The block takes a TGA file one byte per transfer on the slave stream. tuser marks the
// first byte of a file and restarts parsing at any point. The twelve signature bytes are
// checked for uncompressed (type 2) or run-length (type 10) true-colour, then six info
// bytes give width, height and depth. One info record follows, then one pixel record per
// raw pixel, or one record with a repeat count per run packet, colours reordered from
// BGR(A) to RGB(A). Errors (bad signature, bad info, packet overrunning the image) end the
// image; tlast marks the final record of an image, errors included.
// Every byte is handled by a single registered pass: the parser state and the result are
// both updated at the edge that accepts the byte, the record going to the output register,
// or the skid entry if it is full. One byte is taken every cycle while tready is high.
// Results leave through an output register backed by one skid entry; tready on the slave
// side falls only when both hold a record, so a receiver stall costs input cycles only
// once two records are waiting. After reset the block waits for a byte with tuser set;
// bytes after the last pixel, and bytes of a rejected file, are dropped silently.
module tga_image_stream_decoder
  import tgad_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] data_byte
  input  logic                 s_axis_tuser_i,   // [0] first
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_res,
  // [55:40] image_width, [71:56] image_height, [72] has_alpha, [74:73] error_code,
  // [79:75] zero
  output logic [TdataOutW-1:0] m_axis_tdata_o,
  output logic [1:0]           m_axis_tuser_o,   // [1:0] kind
  output logic                 m_axis_tlast_o
);

  // Parser state.
  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] byte_index_q, byte_index_d;
  logic            is_compressed_q, is_compressed_d;
  logic [15:0]     width_q, width_d;
  logic [15:0]     height_q, height_d;
  logic            depth_is_32_q, depth_is_32_d;
  logic [31:0]     pixels_left_q, pixels_left_d;
  logic [7:0]      packet_left_q, packet_left_d;
  logic            packet_is_run_q, packet_is_run_d;
  logic [23:0]     color_q, color_d;
  logic [1:0]      byte_in_pixel_q, byte_in_pixel_d;

  // Output register and skid entry.
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic       accept, take;
  logic [7:0] b;
  phase_e     cur_phase;
  logic [IdxW-1:0] cur_index;
  logic [IdxW-1:0] info_k;

  // Decoded conditions shared by the next-state and result logic.
  logic        sig_bad, sig_end;
  logic        info_end, info_bad;
  logic [7:0]  pkt_count;
  logic        pkt_overrun;
  logic        pix_complete;
  logic [7:0]  rep;
  logic        pix_done, pkt_done;
  logic [23:0] color_now;
  logic        res_valid;
  result_t     res;

  assign s_axis_tready_o = ~skid_valid_q;
  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign take   = out_valid_q & m_axis_tready_i;
  assign b      = s_axis_tdata_i;

  // A first byte restarts parsing as signature byte zero.
  assign cur_phase = s_axis_tuser_i ? PH_SIG : phase_q;
  assign cur_index = s_axis_tuser_i ? '0 : byte_index_q;
  assign info_k    = cur_index - IdxW'(SigLen);

  assign sig_bad = (cur_index == TypeIdx) ? !(b inside {TypeRaw, TypeRle}) : (b != 8'd0);
  assign sig_end = (cur_index == IdxW'(SigLen - 1));

  assign info_end = (cur_index == InfoEnd);
  assign info_bad = (width_q == 16'd0) || (height_q == 16'd0) ||
                    !(color_q[7:0] inside {Depth24, Depth32});

  // Raw header n gives n+1 pixels, run header n gives n-127: both are the low seven bits
  // plus one.
  assign pkt_count   = {1'b0, b[6:0]} + 8'd1;
  assign pkt_overrun = {24'd0, pkt_count} > pixels_left_q;

  assign pix_complete = depth_is_32_q ? (byte_in_pixel_q == 2'd3) : (byte_in_pixel_q == 2'd2);
  assign rep          = (is_compressed_q && packet_is_run_q) ? packet_left_q : 8'd1;
  assign pix_done     = {24'd0, rep} >= pixels_left_q;
  assign pkt_done     = rep >= packet_left_q;

  // Colour bytes with the current byte placed; blue is stored first, red third.
  always_comb begin
    color_now = color_q;
    case (byte_in_pixel_q)
      2'd0:    color_now[7:0]   = b;
      2'd1:    color_now[15:8]  = b;
      2'd2:    color_now[23:16] = b;
      default: color_now = color_q;
    endcase
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = cur_phase;
      case (cur_phase)
        PH_SIG: begin
          if (sig_bad) begin
            phase_d = PH_DONE;
          end else if (sig_end) begin
            phase_d = PH_INFO;
          end
        end
        PH_INFO: begin
          if (info_end) begin
            if (info_bad) begin
              phase_d = PH_DONE;
            end else if (is_compressed_q) begin
              phase_d = PH_PKT;
            end else begin
              phase_d = PH_PIX;
            end
          end
        end
        PH_PKT: begin
          phase_d = pkt_overrun ? PH_DONE : PH_PIX;
        end
        PH_PIX: begin
          if (pix_complete) begin
            if (pix_done) begin
              phase_d = PH_DONE;
            end else if (is_compressed_q && pkt_done) begin
              phase_d = PH_PKT;
            end
          end
        end
        default: phase_d = cur_phase;
      endcase
    end
  end

  // Data state and the result of the accepted byte.
  always_comb begin
    byte_index_d    = byte_index_q;
    is_compressed_d = is_compressed_q;
    width_d         = width_q;
    height_d        = height_q;
    depth_is_32_d   = depth_is_32_q;
    pixels_left_d   = pixels_left_q;
    packet_left_d   = packet_left_q;
    packet_is_run_d = packet_is_run_q;
    color_d         = color_q;
    byte_in_pixel_d = byte_in_pixel_q;
    res_valid       = 1'b0;
    res             = '0;
    if (accept) begin
      byte_index_d = cur_index;
      case (cur_phase)
        PH_SIG: begin
          if (sig_bad) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_SIGNATURE;
            res.last       = 1'b1;
          end else begin
            if (cur_index == TypeIdx) begin
              is_compressed_d = (b == TypeRle);
            end
            byte_index_d = cur_index + IdxW'(1);
          end
        end
        PH_INFO: begin
          byte_index_d = cur_index + IdxW'(1);
          case (info_k)
            5'd0:    width_d[7:0]   = b;
            5'd1:    width_d[15:8]  = b;
            5'd2:    height_d[7:0]  = b;
            5'd3:    height_d[15:8] = b;
            5'd4:    color_d        = {16'd0, b};
            default: color_d        = color_q;
          endcase
          if (info_end) begin
            color_d   = '0;
            res_valid = 1'b1;
            res.last  = info_bad;
            if (info_bad) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_INFO;
            end else begin
              depth_is_32_d    = (color_q[7:0] == Depth32);
              pixels_left_d    = 32'(width_q) * 32'(height_q);
              byte_in_pixel_d  = 2'd0;
              packet_is_run_d  = is_compressed_q ? packet_is_run_q : 1'b0;
              res.kind         = KIND_INFO;
              res.image_width  = width_q;
              res.image_height = height_q;
              res.has_alpha    = (color_q[7:0] == Depth32);
            end
          end
        end
        PH_PKT: begin
          if (pkt_overrun) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_OVERRUN;
            res.last       = 1'b1;
          end else begin
            packet_is_run_d = b[7];
            packet_left_d   = pkt_count;
            byte_in_pixel_d = 2'd0;
            color_d         = '0;
          end
        end
        PH_PIX: begin
          if (pix_complete) begin
            byte_in_pixel_d = 2'd0;
            color_d         = '0;
            pixels_left_d   = pix_done ? 32'd0 : pixels_left_q - {24'd0, rep};
            if (is_compressed_q) begin
              packet_left_d = pkt_done ? 8'd0 : packet_left_q - rep;
            end
            res_valid      = 1'b1;
            res.kind       = KIND_PIXEL;
            res.red        = color_now[23:16];
            res.green      = color_now[15:8];
            res.blue       = color_now[7:0];
            res.alpha      = (byte_in_pixel_q == 2'd3) ? b : 8'd0;
            res.repeat_res = rep;
            res.has_alpha  = depth_is_32_q;
            res.last       = pix_done;
          end else begin
            color_d         = color_now;
            byte_in_pixel_d = byte_in_pixel_q + 2'd1;
          end
        end
        default: byte_index_d = cur_index;
      endcase
    end
  end

  // Output register with one skid entry behind it.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_d) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      byte_index_q    <= '0;
      is_compressed_q <= 1'b0;
      width_q         <= '0;
      height_q        <= '0;
      depth_is_32_q   <= 1'b0;
      pixels_left_q   <= '0;
      packet_left_q   <= '0;
      packet_is_run_q <= 1'b0;
      color_q         <= '0;
      byte_in_pixel_q <= '0;
      out_valid_q     <= 1'b0;
      skid_valid_q    <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      byte_index_q    <= byte_index_d;
      is_compressed_q <= is_compressed_d;
      width_q         <= width_d;
      height_q        <= height_d;
      depth_is_32_q   <= depth_is_32_d;
      pixels_left_q   <= pixels_left_d;
      packet_left_q   <= packet_left_d;
      packet_is_run_q <= packet_is_run_d;
      color_q         <= color_d;
      byte_in_pixel_q <= byte_in_pixel_d;
      out_valid_q     <= out_valid_d;
      skid_valid_q    <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {5'd0, out_q.error_code, out_q.has_alpha, out_q.image_height,
                            out_q.image_width, out_q.repeat_res, out_q.alpha, out_q.blue,
                            out_q.green, out_q.red};

  // The skid entry is only ever filled behind an occupied output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a record while the output register is empty");

  // Pixel bytes are only gathered while pixels of the image remain.
  a_pix_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIX) |-> (pixels_left_q != 32'd0))
    else $error("gathering pixel bytes with no pixels left");

  // A 24-bit pixel never reaches the alpha byte.
  a_no_alpha_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_PIX) && !depth_is_32_q) |-> (byte_in_pixel_q != 2'd3))
    else $error("alpha byte position reached for a 24-bit image");

  // Packet headers are only read for run-length images.
  a_pkt_compressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PKT) |-> is_compressed_q)
    else $error("packet header phase in an uncompressed image");

  // Every error record closes its image.
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == KIND_ERROR)) |-> out_q.last)
    else $error("error record without last");

endmodule
